### hdl/stepper_position_ramp_controller_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the stepper position ramp controller
// Shared concurrent assertion forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef STEPPER_POSITION_RAMP_CONTROLLER_UNIT_MACROS_SVH
`define STEPPER_POSITION_RAMP_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, off while reset is high
`define SPR_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: label");

// next-cycle implication, off while reset is high
`define SPR_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: label");

// next-cycle implication that also holds across reset
`define SPR_ASSERT_NEXT_ALWAYS(label, clk, lhs, rhs) \
   label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
      else $error("assertion failed: label");

`endif

### hdl/spr_pkg.sv
// ---------------------------------------------------------------------------
// Stepper position ramp controller package
// Shared types, constants and the command digit weighting function.
// ---------------------------------------------------------------------------
package spr_pkg;

   // command buffer depth default
   localparam int BUFFER_DEPTH_DEFAULT = 6;

   // characters
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_P    = 8'h50;
   localparam logic [7:0] CHAR_ZERO = 8'd48;

   // register reset values
   localparam logic [15:0] START_PERIOD_RESET     = 16'd1990;
   localparam logic [15:0] MIN_PERIOD_RESET       = 16'd330;
   localparam logic [9:0]  PERIOD_INCREMENT_RESET = 10'd20;
   localparam logic [15:0] DECEL_DISTANCE_RESET   = 16'd83;

   // register map
   typedef enum logic [1:0] {
      REG_START_PERIOD     = 2'd0,
      REG_MIN_PERIOD       = 2'd1,
      REG_PERIOD_INCREMENT = 2'd2,
      REG_DECEL_DISTANCE   = 2'd3
   } reg_index_type;

   // input transaction kinds
   typedef enum logic {
      REQ_BYTE = 1'b0,
      REQ_TICK = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic [15:0] start_period;
      logic [15:0] min_period;
      logic [9:0]  period_increment;
      logic [15:0] decel_distance;
   } cfg_type;

   // completed position command from the buffer
   typedef struct packed {
      logic        load;
      logic [15:0] goal;
   } cmd_type;

   // motion levels and counters after one transaction
   typedef struct packed {
      logic        enable;
      logic        dir_cw;
      logic        step_clk;
      logic        busy;
      logic [15:0] position;
      logic [15:0] goal;
      logic [15:0] period;
   } status_type;

   // weighted sum of four decimal characters, everything wraps to 16 bits
   function automatic logic [15:0] digit_sum(input logic [7:0] c0, input logic [7:0] c1,
                                             input logic [7:0] c2, input logic [7:0] c3);
      logic [15:0] d0;
      logic [15:0] d1;
      logic [15:0] d2;
      logic [15:0] d3;
      d0 = {8'd0, c0} - {8'd0, CHAR_ZERO};
      d1 = {8'd0, c1} - {8'd0, CHAR_ZERO};
      d2 = {8'd0, c2} - {8'd0, CHAR_ZERO};
      d3 = {8'd0, c3} - {8'd0, CHAR_ZERO};
      // x1000 = x1024 - x16 - x8, x100 = x64 + x32 + x4, x10 = x8 + x2
      return ((d0 << 10) - (d0 << 4) - (d0 << 3))
           + ((d1 << 6) + (d1 << 5) + (d1 << 2))
           + ((d2 << 3) + (d2 << 1))
           + d3;
   endfunction

endpackage

### hdl/spr_cmd_buffer.sv
// ---------------------------------------------------------------------------
// Command buffer
// Collects serial characters and decodes a position command on carriage return.
// ---------------------------------------------------------------------------
module spr_cmd_buffer #(
   parameter int BUFFER_DEPTH = spr_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_write,
   input  logic [7:0]       rx_byte,
   output spr_pkg::cmd_type cmd
);

   localparam int IdxWidth = $clog2(BUFFER_DEPTH);
   localparam logic [IdxWidth:0] LastIdx = (IdxWidth + 1)'(BUFFER_DEPTH - 1);

   logic [7:0]          buf_ff [BUFFER_DEPTH];
   logic [IdxWidth-1:0] idx_ff;
   logic [IdxWidth-1:0] idx_in;
   logic [IdxWidth:0]   idx_inc;
   logic [7:0]          cur [5];
   logic                is_cr;

   // buffer contents as seen after this write
   always_comb begin
      for (int k = 0; k < 5; k++) begin
         if (byte_write && (idx_ff == IdxWidth'(k))) begin
            cur[k] = rx_byte;
         end else begin
            cur[k] = buf_ff[k];
         end
      end
   end

   assign is_cr   = (rx_byte == spr_pkg::CHAR_CR);
   assign idx_inc = {1'b0, idx_ff} + 1'b1;

   // index saturates at the last entry, carriage return restarts it
   always_comb begin
      idx_in = idx_ff;
      if (byte_write) begin
         if (is_cr) begin
            idx_in = '0;
         end else if (idx_inc <= LastIdx) begin
            idx_in = idx_inc[IdxWidth-1:0];
         end else begin
            idx_in = LastIdx[IdxWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // buffer storage, undefined until written
   always_ff @(posedge clock) begin
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
         if (byte_write && (idx_ff == IdxWidth'(i))) begin
            buf_ff[i] <= rx_byte;
         end
      end
   end

   // position command decode
   assign cmd.load = byte_write && is_cr && (cur[0] == spr_pkg::CHAR_P);
   assign cmd.goal = spr_pkg::digit_sum(cur[1], cur[2], cur[3], cur[4]);

endmodule

### hdl/spr_motion.sv
// ---------------------------------------------------------------------------
// Motion sequencer
// Tick timer, trapezoidal ramp, direction, step clock and position counter.
// ---------------------------------------------------------------------------
module spr_motion (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                is_tick,
   input  spr_pkg::cmd_type    cmd,
   input  spr_pkg::cfg_type    cfg,
   output logic                rx_allowed,
   output spr_pkg::status_type status
);

   logic        enable_ff, enable_in;
   logic        dir_ff, dir_in;
   logic        clk_ff, clk_in;
   logic        moving_ff, moving_in;
   logic        rx_ff, rx_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] goal_ff, goal_in;
   logic [15:0] period_ff, period_in;
   logic [15:0] tick_ff, tick_in;

   logic [15:0] diff;
   logic        neg;
   logic [16:0] mag;
   logic [15:0] inc16;
   logic [15:0] p_dec;
   logic [16:0] p_sum;
   logic [15:0] p_new;

   // distance to goal and ramp update
   always_comb begin
      diff  = goal_ff - pos_ff;
      neg   = diff[15];
      mag   = neg ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
      inc16 = {6'd0, cfg.period_increment};
      p_dec = period_ff;
      if (period_ff > cfg.min_period) begin
         p_dec = (period_ff >= inc16) ? (period_ff - inc16) : 16'd0;
      end
      p_sum = {1'b0, p_dec} + {1'b0, inc16};
      p_new = p_dec;
      if (mag <= {1'b0, cfg.decel_distance}) begin
         p_new = p_sum[16] ? 16'hFFFF : p_sum[15:0];
      end
   end

   // next state for one transaction
   always_comb begin
      enable_in = enable_ff;
      dir_in    = dir_ff;
      clk_in    = clk_ff;
      moving_in = moving_ff;
      rx_in     = rx_ff;
      pos_in    = pos_ff;
      goal_in   = goal_ff;
      period_in = period_ff;
      tick_in   = tick_ff;
      if (!is_tick) begin
         if (cmd.load) begin
            goal_in = cmd.goal;
            if (cmd.goal != pos_ff) begin
               enable_in = 1'b1;
               moving_in = 1'b1;
               clk_in    = 1'b1;
            end
         end
      end else if (!moving_ff) begin
         tick_in = '0;
      end else if (tick_ff >= period_ff) begin
         // period expiry
         tick_in   = '0;
         rx_in     = 1'b0;
         period_in = p_new;
         if (diff != 16'd0 && !neg) begin
            dir_in = 1'b1;
            if (!clk_ff) begin
               pos_in = pos_ff + 16'd1;
            end
            clk_in = !clk_ff;
         end else if (neg) begin
            dir_in = 1'b0;
            if (!clk_ff) begin
               pos_in = pos_ff - 16'd1;
            end
            clk_in = !clk_ff;
         end else begin
            enable_in = 1'b0;
            rx_in     = 1'b1;
            moving_in = 1'b0;
            period_in = cfg.start_period;
         end
      end else begin
         tick_in = tick_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         dir_ff    <= 1'b0;
         clk_ff    <= 1'b0;
         moving_ff <= 1'b0;
         rx_ff     <= 1'b1;
         pos_ff    <= '0;
         goal_ff   <= '0;
         period_ff <= spr_pkg::START_PERIOD_RESET;
         tick_ff   <= '0;
      end else if (step_en) begin
         enable_ff <= enable_in;
         dir_ff    <= dir_in;
         clk_ff    <= clk_in;
         moving_ff <= moving_in;
         rx_ff     <= rx_in;
         pos_ff    <= pos_in;
         goal_ff   <= goal_in;
         period_ff <= period_in;
         tick_ff   <= tick_in;
      end
   end

   // levels after this transaction go to the result register
   assign rx_allowed      = rx_ff;
   assign status.enable   = enable_in;
   assign status.dir_cw   = dir_in;
   assign status.step_clk = clk_in;
   assign status.busy     = moving_in;
   assign status.position = pos_in;
   assign status.goal     = goal_in;
   assign status.period   = period_in;

endmodule

### hdl/stepper_position_ramp_controller_unit.sv
// ---------------------------------------------------------------------------
// Stepper position ramp controller
// Serial position commands and timer ticks drive a trapezoidal step ramp.
// ---------------------------------------------------------------------------
//  port group   | direction | handshake            | contents
//  req_*        | in        | req_valid/req_ready  | transaction kind, serial character
//  rsp_*        | out       | rsp_valid/rsp_ready  | driver levels, positions, period, taken
//  csr_*        | in        | csr_write_enable     | register index and write data
//
//  One transaction enters per cycle while req_ready is high; it passes the input register
//  and then the result register, where it is offered. All state updates in the single
//  pass between them. Synchronous reset clears control and restores register defaults.
//  A stalled result holds the input register; req_ready falls only while both are
//  full and the result is held, and during reset.
// ---------------------------------------------------------------------------
module stepper_position_ramp_controller_unit #(
   parameter int BUFFER_DEPTH = spr_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [7:0]         req_rx_byte,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_driver_enable,
   output logic               rsp_direction_cw,
   output logic               rsp_step_clock,
   output logic               rsp_busy_res,
   output logic signed [15:0] rsp_current_position,
   output logic signed [15:0] rsp_target_position,
   output logic [15:0]        rsp_step_period,
   output logic               rsp_byte_taken,
   // configuration
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_write_data
);

   logic                s1_valid_ff;
   logic                s1_type_ff;
   logic [7:0]          s1_byte_ff;
   logic                advance;
   logic                is_tick;
   logic                rx_allowed;
   logic                byte_write;
   spr_pkg::cfg_type    cfg_ff;
   spr_pkg::cmd_type    cmd;
   spr_pkg::status_type status;

   logic                rsp_valid_ff;
   spr_pkg::status_type rsp_status_ff;
   logic                rsp_taken_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_period     <= spr_pkg::START_PERIOD_RESET;
         cfg_ff.min_period       <= spr_pkg::MIN_PERIOD_RESET;
         cfg_ff.period_increment <= spr_pkg::PERIOD_INCREMENT_RESET;
         cfg_ff.decel_distance   <= spr_pkg::DECEL_DISTANCE_RESET;
      end else if (csr_write_enable) begin
         unique case (spr_pkg::reg_index_type'(csr_index))
            spr_pkg::REG_START_PERIOD:     cfg_ff.start_period     <= csr_write_data;
            spr_pkg::REG_MIN_PERIOD:       cfg_ff.min_period       <= csr_write_data;
            spr_pkg::REG_PERIOD_INCREMENT: cfg_ff.period_increment <= csr_write_data[9:0];
            spr_pkg::REG_DECEL_DISTANCE:   cfg_ff.decel_distance   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // pipeline flow
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && (!s1_valid_ff || advance);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_type_ff <= req_type;
         s1_byte_ff <= req_rx_byte;
      end
   end

   assign is_tick    = (spr_pkg::req_kind_type'(s1_type_ff) == spr_pkg::REQ_TICK);
   assign byte_write = advance && !is_tick && rx_allowed;

   spr_cmd_buffer #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_cmd_buffer (
      .clock     (clock),
      .reset     (reset),
      .byte_write(byte_write),
      .rx_byte   (s1_byte_ff),
      .cmd       (cmd)
   );

   spr_motion u_motion (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .is_tick   (is_tick),
      .cmd       (cmd),
      .cfg       (cfg_ff),
      .rx_allowed(rx_allowed),
      .status    (status)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= status;
         rsp_taken_ff  <= !is_tick && rx_allowed;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_driver_enable    = rsp_status_ff.enable;
   assign rsp_direction_cw     = rsp_status_ff.dir_cw;
   assign rsp_step_clock       = rsp_status_ff.step_clk;
   assign rsp_busy_res         = rsp_status_ff.busy;
   assign rsp_current_position = $signed(rsp_status_ff.position);
   assign rsp_target_position  = $signed(rsp_status_ff.goal);
   assign rsp_step_period      = rsp_status_ff.period;
   assign rsp_byte_taken       = rsp_taken_ff;

endmodule

### hdl/spr_checker.sv
// ---------------------------------------------------------------------------
// Port checker
// Watches the top level's ports for result handshake and status consistency.
// ---------------------------------------------------------------------------
`include "stepper_position_ramp_controller_unit_macros.svh"

module spr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_driver_enable,
   input logic               rsp_busy_res,
   input logic signed [15:0] rsp_current_position,
   input logic [15:0]        rsp_step_period
);

   // a stalled result keeps its position and period
   `SPR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_current_position) && $stable(rsp_step_period))

   // the driver is enabled exactly while a move runs
   `SPR_ASSERT_IMPLIES(a_enable_busy, clock, reset, rsp_valid, rsp_driver_enable == rsp_busy_res)

   // input backs up only behind a stalled result
   `SPR_ASSERT_IMPLIES(a_ready_stall, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // reset empties the result side
   `SPR_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind stepper_position_ramp_controller_unit spr_checker u_spr_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_driver_enable   (rsp_driver_enable),
   .rsp_busy_res        (rsp_busy_res),
   .rsp_current_position(rsp_current_position),
   .rsp_step_period     (rsp_step_period)
);
